@@ rtl/frg_pkg.sv @@
// Shared constants and controller/datapath interface types for the fraction reducer.
package frg_pkg;

    localparam int FIELD_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int DEF_WIDTH  = 32;
    localparam int IN_DATA_W  = ((2 * FIELD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((3 * FIELD_W + STATUS_W + 7) / 8) * 8;

    localparam logic [STATUS_W-1:0] ST_REDUCED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_NUM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd2;

    typedef struct packed {
        logic load;      // capture a new fraction
        logic gcd_step;  // one binary gcd reduction step
        logic div_init;  // form the gcd and start both dividers
        logic div_step;  // one quotient bit in both dividers
        logic out_load;  // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic num_zero;
        logic den_zero;
        logic gcd_done;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/frg_div.sv @@
// Restoring divider that retires one quotient bit per step.
module frg_div #(
    parameter int WIDTH = frg_pkg::DEF_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_start,
    input  logic             i_step,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic [WIDTH-1:0] o_quotient
);

    logic [WIDTH-1:0] r_quot;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_dsr;
    logic [WIDTH:0]   rem_sh;
    logic [WIDTH-1:0] rem_sub;
    logic             fits;

    always_comb begin
        rem_sh  = {r_rem, r_quot[WIDTH-1]};
        // only taken when it fits, so the difference is below the divisor
        rem_sub = rem_sh[WIDTH-1:0] - r_dsr;
        fits    = (rem_sh >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dsr  <= i_divisor;
        end else if (i_step) begin
            r_quot <= {r_quot[WIDTH-2:0], fits};
            // remainder stays below the divisor, so the top bit is zero
            r_rem  <= fits ? rem_sub : rem_sh[WIDTH-1:0];
        end
    end

    assign o_quotient = r_quot;

endmodule

@@ rtl/frg_dpath.sv @@
// Datapath: operand registers, binary gcd unit, two dividers and output register.
module frg_dpath #(
    parameter int WIDTH = frg_pkg::DEF_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  frg_pkg::t_cmd                    i_cmd,
    output frg_pkg::t_stat                   o_stat,
    input  logic [frg_pkg::IN_DATA_W-1:0]    i_in_data,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [frg_pkg::OUT_DATA_W-1:0]   o_out_data
);

    localparam int KW = $clog2(WIDTH);

    logic [WIDTH-1:0] in_num;
    logic [WIDTH-1:0] in_den;

    logic [WIDTH-1:0] r_num;
    logic [WIDTH-1:0] r_den;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [KW-1:0]    r_k;
    logic             r_num_zero;
    logic             r_den_zero;
    logic             r_out_valid;

    logic [frg_pkg::FIELD_W-1:0]  r_rn;
    logic [frg_pkg::FIELD_W-1:0]  r_rd;
    logic [frg_pkg::FIELD_W-1:0]  r_g_out;
    logic [frg_pkg::STATUS_W-1:0] r_status;

    logic [WIDTH-1:0] n_a;
    logic [WIDTH-1:0] n_b;
    logic [KW-1:0]    n_k;
    logic [WIDTH-1:0] gcd_val;
    logic [WIDTH-1:0] quot_num;
    logic [WIDTH-1:0] quot_den;

    assign in_num = WIDTH'(i_in_data[frg_pkg::FIELD_W-1:0]);
    assign in_den = WIDTH'(i_in_data[2*frg_pkg::FIELD_W-1:frg_pkg::FIELD_W]);

    // Stein step: strip common twos into k, strip lone twos, halve the odd difference
    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_k = r_k;
        if (!r_a[0] && !r_b[0]) begin
            n_a = r_a >> 1;
            n_b = r_b >> 1;
            n_k = r_k + 1'b1;
        end else if (!r_a[0]) begin
            n_a = r_a >> 1;
        end else if (!r_b[0]) begin
            n_b = r_b >> 1;
        end else if (r_a >= r_b) begin
            n_a = (r_a - r_b) >> 1;
        end else begin
            n_b = (r_b - r_a) >> 1;
        end
    end

    assign gcd_val = (r_a | r_b) << r_k;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num      <= in_num;
            r_den      <= in_den;
            r_a        <= in_num;
            r_b        <= in_den;
            r_k        <= '0;
            r_num_zero <= (in_num == '0);
            r_den_zero <= (in_den == '0);
        end else if (i_cmd.gcd_step) begin
            r_a <= n_a;
            r_b <= n_b;
            r_k <= n_k;
        end else if (i_cmd.div_init) begin
            r_a <= gcd_val;
        end
    end

    frg_div #(.WIDTH(WIDTH)) u_div_num (
        .i_clk      (i_clk),
        .i_start    (i_cmd.div_init),
        .i_step     (i_cmd.div_step),
        .i_dividend (r_num),
        .i_divisor  (gcd_val),
        .o_quotient (quot_num)
    );

    frg_div #(.WIDTH(WIDTH)) u_div_den (
        .i_clk      (i_clk),
        .i_start    (i_cmd.div_init),
        .i_step     (i_cmd.div_step),
        .i_dividend (r_den),
        .i_divisor  (gcd_val),
        .o_quotient (quot_den)
    );

    // after div_init r_a holds the gcd
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_num_zero) begin
                r_rn     <= '0;
                r_rd     <= frg_pkg::FIELD_W'(1);
                r_g_out  <= '0;
                r_status <= frg_pkg::ST_ZERO_NUM;
            end else if (r_den_zero) begin
                r_rn     <= '0;
                r_rd     <= '0;
                r_g_out  <= '0;
                r_status <= frg_pkg::ST_DIV_ZERO;
            end else begin
                r_rn     <= frg_pkg::FIELD_W'(quot_num);
                r_rd     <= frg_pkg::FIELD_W'(quot_den);
                r_g_out  <= frg_pkg::FIELD_W'(r_a);
                r_status <= frg_pkg::ST_REDUCED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.num_zero = r_num_zero;
    assign o_stat.den_zero = r_den_zero;
    assign o_stat.gcd_done = (r_a == '0) || (r_b == '0);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = frg_pkg::OUT_DATA_W'({r_status, r_g_out, r_rd, r_rn});

endmodule

@@ rtl/frg_ctrl.sv @@
// Controller state machine sequencing capture, gcd, division and result hand-off.
module frg_ctrl #(
    parameter int WIDTH = frg_pkg::DEF_WIDTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  frg_pkg::t_stat i_stat,
    output frg_pkg::t_cmd  o_cmd
);

    localparam int CW = $clog2(WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_DIV,
        S_OUT
    } t_state;

    t_state         r_state;
    logic [CW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (i_stat.num_zero || i_stat.den_zero) begin
                        r_state <= S_OUT;
                    end else if (i_stat.gcd_done) begin
                        r_state <= S_DIV;
                        r_cnt   <= '0;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(WIDTH - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.gcd_step = (r_state == S_GCD) && !i_stat.num_zero && !i_stat.den_zero
                         && !i_stat.gcd_done;
        o_cmd.div_init = (r_state == S_GCD) && !i_stat.num_zero && !i_stat.den_zero
                         && i_stat.gcd_done;
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.out_load = (r_state == S_OUT) && i_stat.out_free;
    end

endmodule

@@ rtl/fraction_reduce_gcd_core.sv @@
// Top level of the fraction reducer: binary gcd followed by two restoring dividers.
//
//  channel   | dir | tdata fields (low bit up)
//  s_axis    | in  | numerator_in[31:0], denominator_in[63:32]
//  m_axis    | out | reduced_numerator[31:0], reduced_denominator[63:32],
//            |     | common_divisor[95:64], status[97:96], zero pad to 104
//
// One fraction at a time. Binary gcd takes one cycle per step, at most 2*WIDTH
// steps; both quotients then come from two dividers working side by side, and
// the result is then loaded for hand-off. A zero operand skips to the result.
// Reset (i_rst_n low at a clock edge) clears the controller and output valid.
// A stalled result holds in the output register and the next result waits for it;
// the next fraction is taken as soon as the previous result has been loaded.
module fraction_reduce_gcd_core #(
    parameter int WIDTH = frg_pkg::DEF_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [frg_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // numerator, denominator
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [frg_pkg::OUT_DATA_W-1:0] m_axis_tdata    // rn, rd, gcd, status, pad
);

    frg_pkg::t_cmd  cmd;
    frg_pkg::t_stat stat;

    frg_ctrl #(.WIDTH(WIDTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    frg_dpath #(.WIDTH(WIDTH)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // one fraction in flight: after a transfer the input side closes
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a fraction is in flight");

    // a reduced result has a nonzero gcd and nonzero parts
    a_reduced_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[97:96] == frg_pkg::ST_REDUCED) |->
        (m_axis_tdata[95:64] != 32'd0) && (m_axis_tdata[63:32] != 32'd0)
        && (m_axis_tdata[31:0] != 32'd0))
        else $error("reduced result with a zero part");

    // zero numerator always yields 0/1 with no gcd
    a_zero_num_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[97:96] == frg_pkg::ST_ZERO_NUM) |->
        (m_axis_tdata[31:0] == 32'd0) && (m_axis_tdata[63:32] == 32'd1)
        && (m_axis_tdata[95:64] == 32'd0))
        else $error("zero numerator result is not 0/1");
`endif

endmodule

@@ test/tb_fraction_reduce_gcd_core.sv @@
// Self-checking stream testbench for the fraction reducer with gcd and quotient prediction.
module tb_fraction_reduce_gcd_core;

    typedef struct packed {
        logic [frg_pkg::FIELD_W-1:0]  num;
        logic [frg_pkg::FIELD_W-1:0]  den;
        logic [frg_pkg::FIELD_W-1:0]  gcd;
        logic [frg_pkg::STATUS_W-1:0] status;
    } t_reduced_fraction;

    localparam int FW = frg_pkg::FIELD_W;
    localparam int SW = frg_pkg::STATUS_W;

    localparam logic [FW-1:0] MAX_VAL = '1;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [frg_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;   // numerator_in, denominator_in
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [frg_pkg::OUT_DATA_W-1:0] m_axis_tdata;         // rn, rd, gcd, status, pad

    t_reduced_fraction pending_reductions[$];
    int                mismatch_count = 0;
    int                gap_pct        = 0;
    int                stall_pct      = 0;

    fraction_reduce_gcd_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Euclid on (denominator, numerator), then divide both parts by the gcd.
    function automatic t_reduced_fraction reduce_fraction(input logic [FW-1:0] num,
                                                          input logic [FW-1:0] den);
        t_reduced_fraction res;
        logic [FW-1:0] x;
        logic [FW-1:0] y;
        logic [FW-1:0] r;
        if (num == '0) begin
            res = '{num: '0, den: 1, gcd: '0, status: frg_pkg::ST_ZERO_NUM};
        end else if (den == '0) begin
            res = '{num: '0, den: '0, gcd: '0, status: frg_pkg::ST_DIV_ZERO};
        end else begin
            x = den;
            y = num;
            while (y != '0) begin
                r = x % y;
                x = y;
                y = r;
            end
            res = '{num: num / x, den: den / x, gcd: x, status: frg_pkg::ST_REDUCED};
        end
        return res;
    endfunction

    // Hold tvalid low for a random gap, then present one fraction until its transfer.
    task automatic send_fraction(input logic [FW-1:0] num, input logic [FW-1:0] den);
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {den, num};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_reductions.push_back(reduce_fraction(num, den));
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        while (pending_reductions.size() != 0) @(posedge i_clk);
    endtask

    task automatic pick_fraction(output logic [FW-1:0] num,
                                 output logic [FW-1:0] den);
        int            kind;
        logic [FW-1:0] g;
        kind = $urandom_range(99);
        if (kind < 30) begin
            num = $urandom;
            den = $urandom;
        end else if (kind < 55) begin
            // shared factor g so the gcd is at least g
            g   = $urandom_range(1, 65535);
            num = $urandom_range(1, 65535) * g;
            den = $urandom_range(1, 65535) * g;
        end else if (kind < 65) begin
            num = ($urandom | 1) << $urandom_range(0, 31);
            den = ($urandom | 1) << $urandom_range(0, 31);
        end else if (kind < 75) begin
            num = $urandom_range(0, 255);
            den = $urandom_range(0, 255);
        end else if (kind < 85) begin
            num = $urandom_range(1, 65535);
            den = num * $urandom_range(0, 65535);
            if ($urandom_range(1)) begin
                g   = num;
                num = den;
                den = g;
            end
        end else if (kind < 88) begin
            num = $urandom;
            den = num;
        end else if (kind < 94) begin
            num = '0;
            den = $urandom_range(1) ? $urandom : '0;
        end else begin
            num = $urandom;
            den = '0;
        end
    endtask

    task automatic send_random_fractions(input int count);
        logic [FW-1:0] num;
        logic [FW-1:0] den;
        for (int i = 0; i < count; i++) begin
            pick_fraction(num, den);
            send_fraction(num, den);
        end
    endtask

    task automatic test_special_cases();
        gap_pct   = 0;
        stall_pct = 0;
        send_fraction('0, '0);          // zero numerator wins over zero denominator
        send_fraction('0, MAX_VAL);
        send_fraction('0, 1);
        send_fraction(5, '0);
        send_fraction(MAX_VAL, '0);
        send_fraction(1, 1);
        send_fraction(MAX_VAL, MAX_VAL);
        send_fraction(MAX_VAL, 1);
        send_fraction(1, MAX_VAL);
        send_fraction(MAX_VAL, MAX_VAL - 1);
        send_fraction(MAX_VAL - 1, MAX_VAL);
        send_fraction(32'h8000_0000, 32'h8000_0000);
        send_fraction(32'h8000_0000, 32'h4000_0000);
        send_fraction(32'h4000_0000, 32'hC000_0000);
        send_fraction(12, 18);
        send_fraction(18, 12);
        // consecutive Fibonacci numbers: longest remainder chain
        send_fraction(32'd1836311903, 32'd2971215073);
        send_fraction(32'd2971215073, 32'd1836311903);
        send_fraction(32'hFFFF_0000, 32'h7FFF_8000);
        send_fraction(32'hAAAA_AAAA, 32'h5555_5555);
        send_fraction(32'h5555_5555, 32'hAAAA_AAAA);
        send_fraction(32'd4294967291, 32'd4294967279);
        stop_sending();
        wait_for_results();
    endtask

    task automatic test_stream_back_to_back();
        gap_pct   = 0;
        stall_pct = 0;
        send_random_fractions(400);
        stop_sending();
    endtask

    task automatic test_sender_gaps();
        gap_pct   = 60;
        stall_pct = 0;
        send_random_fractions(400);
        stop_sending();
    endtask

    task automatic test_result_backpressure();
        gap_pct   = 0;
        stall_pct = 60;
        send_random_fractions(400);
        stop_sending();
    endtask

    task automatic test_mixed_idling();
        gap_pct   = 15;
        stall_pct = 15;
        send_random_fractions(400);
        stop_sending();
    endtask

    // Drain the block completely before each new fraction.
    task automatic test_drain_pause();
        logic [FW-1:0] num;
        logic [FW-1:0] den;
        gap_pct   = 15;
        stall_pct = 60;
        for (int i = 0; i < 20; i++) begin
            pick_fraction(num, den);
            send_fraction(num, den);
            stop_sending();
            wait_for_results();
        end
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_reduced_fraction want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_reductions.size() == 0) begin
                $error("result transfer with nothing pending: tdata %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_reductions.pop_front();
                if (m_axis_tdata[FW-1:0] !== want.num) begin
                    $error("reduced_numerator: expected %0d, got %0d",
                           want.num, m_axis_tdata[FW-1:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[2*FW-1:FW] !== want.den) begin
                    $error("reduced_denominator: expected %0d, got %0d",
                           want.den, m_axis_tdata[2*FW-1:FW]);
                    mismatch_count++;
                end
                if (m_axis_tdata[3*FW-1:2*FW] !== want.gcd) begin
                    $error("common_divisor: expected %0d, got %0d",
                           want.gcd, m_axis_tdata[3*FW-1:2*FW]);
                    mismatch_count++;
                end
                if (m_axis_tdata[3*FW+SW-1:3*FW] !== want.status) begin
                    $error("status: expected %0d, got %0d",
                           want.status, m_axis_tdata[3*FW+SW-1:3*FW]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_cases();
        test_stream_back_to_back();
        test_sender_gaps();
        test_result_backpressure();
        test_mixed_idling();
        test_drain_pause();
        wait_for_results();
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ fraction_reduce_gcd_core.f @@
rtl/frg_pkg.sv
rtl/frg_div.sv
rtl/frg_dpath.sv
rtl/frg_ctrl.sv
rtl/fraction_reduce_gcd_core.sv
test/tb_fraction_reduce_gcd_core.sv
